/* hw/rtl/nms_pkg.sv */
// Shared types and constants of the neighbor mean stencil.
package nms_pkg;

  localparam int SIDE_W     = 6;
  localparam int PIX_W      = 8;
  localparam int MEAN_W     = 17;
  localparam int SUM_W      = 10;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  // configuration register indexes
  localparam logic REG_SIDE_LENGTH = 1'b0;

  localparam logic [SIDE_W-1:0] SIDE_RESET = 6'd8;
  localparam logic [SIDE_W-1:0] SIDE_MIN   = 6'd2;

  // neighbor counts
  localparam logic [2:0] NB_TWO   = 3'd2;
  localparam logic [2:0] NB_THREE = 3'd3;
  localparam logic [2:0] NB_FOUR  = 3'd4;

  // (sum * 256) / 3 = 85 * sum + sum / 3, with sum / 3 = (sum * 683) >> 11 for sum < 2048
  localparam int DIV3_BASE  = 85;
  localparam int DIV3_MUL   = 683;
  localparam int DIV3_SHIFT = 11;
  localparam int DIV3_PW    = 20;

  localparam int QUEUE_DEPTH = 2;
  localparam int Q_AW        = $clog2(QUEUE_DEPTH);

  // one classified pixel on its way from front to back
  typedef struct packed {
    logic [PIX_W-1:0]  pixel;
    logic [SIDE_W-1:0] row;
    logic [SIDE_W-1:0] col;
    logic [1:0]        slot;  // row mod 3
    logic              last;  // last pixel of the image
  } job_t;

endpackage

/* hw/rtl/nms_if.sv */
// Stream interfaces for the pixel input and the mean result channels.
interface nms_pix_if;
  import nms_pkg::*;
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel;

  modport source (output valid, output pixel, input ready);
  modport sink (input valid, input pixel, output ready);
endinterface

interface nms_res_if;
  import nms_pkg::*;
  logic              valid;
  logic              ready;
  logic [MEAN_W-1:0] mean_value;
  logic              frame_last;

  modport source (output valid, output mean_value, output frame_last, input ready);
  modport sink (input valid, input mean_value, input frame_last, output ready);
endinterface

/* hw/rtl/neighbor_mean_stencil_top.sv */
// Four-neighbor mean filter over a square image streamed in raster order, one 8-bit
// pixel per item. Each result is the mean of the existing up, down, left and right
// neighbors (2 at corners, 3 on edges, 4 inside) as unsigned fixed point with 8
// fraction bits, truncated. The result for row r, column c leaves after pixel
// (r+1, c) arrives; the last pixel of the image also releases the whole last row,
// with frame_last set on its final result. Pixels of row 0 produce no result.
// In the back end, a pixel without a result is only popped and stored; one with a result
// goes through pop, neighbor fetch from the two-read-port row store as three reads, sum,
// then divide and load, plus any output stall. The last pixel of an image then releases
// the last row, each result through fetch, sum, and divide and load. A two-item queue
// lets the input keep flowing while the back end works or the output stalls.
// side_length (offset 0x0) is clamped to 2..MAX_SIDE, and writing it restarts the image.
module neighbor_mean_stencil_top #(
  parameter int MAX_SIDE = 32
) (
  input  logic                           clk,
  input  logic                           rst_n,
  nms_pix_if.sink                        in_ch,
  nms_res_if.source                      out_ch,
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [nms_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [nms_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic [nms_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output logic                           cfg_pready
);
  import nms_pkg::*;

  logic [SIDE_W-1:0] side_r, eff_side;
  logic              sel_side, cfg_wr;
  logic              q_push_valid, q_push_ready, q_pop_valid, q_pop;
  job_t              q_push_job, q_pop_job;

  assign cfg_pready = 1'b1;
  assign sel_side   = (cfg_paddr[CFG_ADDR_W-1:2] == REG_SIDE_LENGTH);
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && sel_side;
  assign cfg_prdata = sel_side ? CFG_DATA_W'(side_r) : '0;

  always_comb begin
    if (side_r < SIDE_MIN) begin
      eff_side = SIDE_MIN;
    end else if (side_r > SIDE_W'(MAX_SIDE)) begin
      eff_side = SIDE_W'(MAX_SIDE);
    end else begin
      eff_side = side_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_r <= SIDE_RESET;
    end else if (cfg_wr) begin
      side_r <= cfg_pwdata[SIDE_W-1:0];
    end
  end

  nms_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .side      (eff_side),
    .clear     (cfg_wr),
    .in_valid  (in_ch.valid),
    .in_pixel  (in_ch.pixel),
    .in_ready  (in_ch.ready),
    .job_valid (q_push_valid),
    .job       (q_push_job),
    .job_ready (q_push_ready)
  );

  nms_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (q_push_valid),
    .push_job   (q_push_job),
    .push_ready (q_push_ready),
    .pop_valid  (q_pop_valid),
    .pop_job    (q_pop_job),
    .pop        (q_pop)
  );

  nms_back #(.MAX_SIDE(MAX_SIDE)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .side      (eff_side),
    .job_valid (q_pop_valid),
    .job       (q_pop_job),
    .job_pop   (q_pop),
    .out_valid (out_ch.valid),
    .out_mean  (out_ch.mean_value),
    .out_last  (out_ch.frame_last),
    .out_ready (out_ch.ready)
  );
endmodule

/* hw/rtl/nms_ram.sv */
// Generic RAM: one write port, two read ports, registered read data.
module nms_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 96
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);
  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_a <= mem_r[raddr_a];
    rdata_b <= mem_r[raddr_b];
  end
endmodule

/* hw/rtl/nms_front.sv */
// Front end: accepts pixels, tracks row and column, tags each item for the back end.
module nms_front (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [nms_pkg::SIDE_W-1:0] side,
  input  logic                      clear,
  input  logic                      in_valid,
  input  logic [nms_pkg::PIX_W-1:0] in_pixel,
  output logic                      in_ready,
  output logic                      job_valid,
  output nms_pkg::job_t             job,
  input  logic                      job_ready
);
  import nms_pkg::*;

  logic [SIDE_W-1:0] row_r, row_nxt, col_r, col_nxt;
  logic [1:0]        slot_r, slot_nxt;
  logic [SIDE_W-1:0] cur_row, cur_col;
  logic [1:0]        cur_slot;
  logic              wrap, accept, end_col, end_row;

  always_comb begin
    // counters beyond a shrunken side start a new image
    wrap     = (row_r >= side) || (col_r >= side);
    cur_row  = wrap ? '0 : row_r;
    cur_col  = wrap ? '0 : col_r;
    cur_slot = wrap ? '0 : slot_r;
    end_col  = (cur_col == side - 6'd1);
    end_row  = (cur_row == side - 6'd1);

    job.pixel = in_pixel;
    job.row   = cur_row;
    job.col   = cur_col;
    job.slot  = cur_slot;
    job.last  = end_row && end_col;

    job_valid = in_valid;
    in_ready  = job_ready;
    accept    = in_valid && job_ready;

    row_nxt  = row_r;
    col_nxt  = col_r;
    slot_nxt = slot_r;
    if (clear) begin
      row_nxt  = '0;
      col_nxt  = '0;
      slot_nxt = '0;
    end else if (accept) begin
      if (end_col) begin
        col_nxt = '0;
        if (end_row) begin
          row_nxt  = '0;
          slot_nxt = '0;
        end else begin
          row_nxt  = cur_row + 6'd1;
          slot_nxt = (cur_slot == 2'd2) ? 2'd0 : cur_slot + 2'd1;
        end
      end else begin
        row_nxt  = cur_row;
        slot_nxt = cur_slot;
        col_nxt  = cur_col + 6'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r  <= '0;
      col_r  <= '0;
      slot_r <= '0;
    end else begin
      row_r  <= row_nxt;
      col_r  <= col_nxt;
      slot_r <= slot_nxt;
    end
  end
endmodule

/* hw/rtl/nms_queue.sv */
// Short queue of tagged items between front and back end.
module nms_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push_valid,
  input  nms_pkg::job_t push_job,
  output logic          push_ready,
  output logic          pop_valid,
  output nms_pkg::job_t pop_job,
  input  logic          pop
);
  import nms_pkg::*;

  job_t            mem_r [QUEUE_DEPTH];
  logic [Q_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [Q_AW:0]   cnt_r, cnt_nxt;
  logic            do_push, do_pop;

  always_comb begin
    push_ready = (cnt_r != (Q_AW+1)'(QUEUE_DEPTH));
    pop_valid  = (cnt_r != '0);
    pop_job    = mem_r[rd_ptr_r];
    do_push    = push_valid && push_ready;
    do_pop     = pop && pop_valid;
    cnt_nxt    = cnt_r + (Q_AW+1)'(do_push) - (Q_AW+1)'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      cnt_r <= cnt_nxt;
    end
  end
endmodule

/* hw/rtl/nms_back.sv */
// Back end: row store, neighbor fetch sequencer, mean arithmetic and result register.
module nms_back #(
  parameter int MAX_SIDE = 32
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [nms_pkg::SIDE_W-1:0] side,
  input  logic                       job_valid,
  input  nms_pkg::job_t              job,
  output logic                       job_pop,
  output logic                       out_valid,
  output logic [nms_pkg::MEAN_W-1:0] out_mean,
  output logic                       out_last,
  input  logic                       out_ready
);
  import nms_pkg::*;

  localparam int DEPTH = 3 * MAX_SIDE;
  localparam int AW    = $clog2(DEPTH);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_RDA  = 5'b00010,
    ST_RDB  = 5'b00100,
    ST_SUM  = 5'b01000,
    ST_OUT  = 5'b10000
  } back_state_t;

  function automatic logic [1:0] slot_prev(input logic [1:0] s);
    return (s == 2'd0) ? 2'd2 : s - 2'd1;
  endfunction

  function automatic logic [AW-1:0] ram_addr(input logic [1:0] s, input logic [SIDE_W-1:0] c);
    return AW'(s) * AW'(MAX_SIDE) + AW'(c);
  endfunction

  back_state_t       state_r, state_nxt;
  job_t              job_r;
  logic              flush_r, flush_nxt;
  logic [SIDE_W-1:0] col_r, col_nxt;
  logic [PIX_W-1:0]  up_r, left_r;
  logic [SUM_W-1:0]  sum_r;
  logic [2:0]        cnt_r;
  logic              out_valid_r;
  logic [MEAN_W-1:0] out_mean_r;
  logic              out_last_r;

  logic              has_up, has_down, has_left, has_right, col_end;
  logic [1:0]        o_slot, up_slot;
  logic [SIDE_W-1:0] left_col, right_col;
  logic [AW-1:0]     raddr_a, raddr_b, waddr;
  logic [PIX_W-1:0]  rdata_a, rdata_b;
  logic              we, load_out;
  logic [SUM_W-1:0]  sum_nxt;
  logic [2:0]        cnt_nxt;
  logic [MEAN_W-1:0] mean, prod_base;
  logic [DIV3_PW-1:0] prod_frac;

  nms_ram #(.WIDTH(PIX_W), .DEPTH(DEPTH)) u_ram (
    .clk     (clk),
    .we      (we),
    .waddr   (waddr),
    .wdata   (job.pixel),
    .raddr_a (raddr_a),
    .raddr_b (raddr_b),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b)
  );

  // neighbor geometry of the output pixel; during flush it lies in the job's own row
  always_comb begin
    col_end   = (col_r == side - 6'd1);
    has_up    = flush_r || (job_r.row >= 6'd2);
    has_down  = !flush_r;
    has_left  = (col_r != '0);
    has_right = !col_end;
    o_slot    = flush_r ? job_r.slot : slot_prev(job_r.slot);
    up_slot   = slot_prev(o_slot);
    left_col  = has_left ? col_r - 6'd1 : col_r;
    right_col = has_right ? col_r + 6'd1 : col_r;
    raddr_a   = (state_r == ST_RDB) ? ram_addr(o_slot, right_col) : ram_addr(up_slot, col_r);
    raddr_b   = ram_addr(o_slot, left_col);
    waddr     = ram_addr(job.slot, job.col);
  end

  always_comb begin
    sum_nxt = SUM_W'(has_up ? up_r : '0) + SUM_W'(has_down ? job_r.pixel : '0)
            + SUM_W'(has_left ? left_r : '0) + SUM_W'(has_right ? rdata_a : '0);
    cnt_nxt = 3'(has_up) + 3'(has_down) + 3'(has_left) + 3'(has_right);

    prod_base = MEAN_W'(sum_r) * MEAN_W'(DIV3_BASE);
    prod_frac = DIV3_PW'(sum_r) * DIV3_PW'(DIV3_MUL);
    unique case (cnt_r)
      NB_TWO:   mean = MEAN_W'({sum_r, 7'b0});
      NB_THREE: mean = prod_base + MEAN_W'(prod_frac >> DIV3_SHIFT);
      NB_FOUR:  mean = MEAN_W'({sum_r, 6'b0});
      default:  mean = MEAN_W'({sum_r, 6'b0});
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    flush_nxt = flush_r;
    col_nxt   = col_r;
    job_pop   = 1'b0;
    we        = 1'b0;
    load_out  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (job_valid) begin
          job_pop = 1'b1;
          we      = 1'b1;
          col_nxt = job.col;
          // first row of the image yields nothing yet
          if (job.row != '0) begin
            state_nxt = ST_RDA;
          end
        end
      end
      ST_RDA: state_nxt = ST_RDB;
      ST_RDB: state_nxt = ST_SUM;
      ST_SUM: state_nxt = ST_OUT;
      ST_OUT: begin
        if (!out_valid_r || out_ready) begin
          load_out = 1'b1;
          if (flush_r) begin
            if (col_end) begin
              flush_nxt = 1'b0;
              state_nxt = ST_IDLE;
            end else begin
              col_nxt   = col_r + 6'd1;
              state_nxt = ST_RDA;
            end
          end else if (job_r.last) begin
            // last pixel: emit the whole last row
            flush_nxt = 1'b1;
            col_nxt   = '0;
            state_nxt = ST_RDA;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (job_pop) begin
      job_r <= job;
    end
    if (state_r == ST_RDB) begin
      up_r   <= rdata_a;
      left_r <= rdata_b;
    end
    if (state_r == ST_SUM) begin
      sum_r <= sum_nxt;
      cnt_r <= cnt_nxt;
    end
    if (load_out) begin
      out_mean_r <= mean;
      out_last_r <= flush_r && col_end;
    end
    col_r <= col_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      flush_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      flush_r <= flush_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_mean  = out_mean_r;
  assign out_last  = out_last_r;
endmodule

/* hw/rtl/nms_checker.sv */
// Port-level assertions for the neighbor mean stencil, bound to the top level.
module nms_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [nms_pkg::MEAN_W-1:0]     out_mean,
  input logic                           out_last,
  input logic                           cfg_psel,
  input logic                           cfg_penable,
  input logic                           cfg_pwrite,
  input logic                           cfg_pready,
  input logic [nms_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input logic [nms_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  input logic [nms_pkg::CFG_DATA_W-1:0] cfg_prdata
);
  import nms_pkg::*;

  // a stalled result holds its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_mean) && $stable(out_last))
    else $error("result changed while stalled");

  // nothing comes out right after reset
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // a mean never exceeds 130560, the largest two-neighbor sum with 8 fraction bits
  a_mean_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_mean <= 17'd130560)
    else $error("mean out of range");

  // a side_length write reads back on the next cycle
  a_cfg_readback: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_psel && cfg_penable && cfg_pwrite && cfg_pready
      && (cfg_paddr[CFG_ADDR_W-1:2] == REG_SIDE_LENGTH)
    |=> (cfg_paddr[CFG_ADDR_W-1:2] != REG_SIDE_LENGTH)
      || (cfg_prdata[SIDE_W-1:0] == $past(cfg_pwdata[SIDE_W-1:0])))
    else $error("side_length readback mismatch");
endmodule

bind neighbor_mean_stencil_top nms_checker u_nms_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .out_mean    (out_ch.mean_value),
  .out_last    (out_ch.frame_last),
  .cfg_psel    (cfg_psel),
  .cfg_penable (cfg_penable),
  .cfg_pwrite  (cfg_pwrite),
  .cfg_pready  (cfg_pready),
  .cfg_paddr   (cfg_paddr),
  .cfg_pwdata  (cfg_pwdata),
  .cfg_prdata  (cfg_prdata)
);
